>>> hw/rtl/pin_change_edge_dispatcher_unit_macros.svh
// Assertion macros used by the pin change edge dispatcher top level
`ifndef PIN_CHANGE_EDGE_DISPATCHER_UNIT_MACROS_SVH
`define PIN_CHANGE_EDGE_DISPATCHER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define PCED_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define PCED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pced_pkg.sv
// Types, codes and the package pin table of the pin change edge dispatcher
package pced_pkg;

  localparam int PINS_PER_PORT = 8;
  localparam int BIT_W = 3;
  localparam int PORT_W = 2;
  localparam int TAG_W = 8;
  localparam int EN_W = 3;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_REGISTER = 2'd1;
  localparam logic [1:0] MODE_DEREGISTER = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_UNCHANGED = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [PORT_W-1:0] PORT_B = 2'd0;
  localparam logic [PORT_W-1:0] PORT_C = 2'd1;
  localparam logic [PORT_W-1:0] PORT_D = 2'd2;

  localparam logic [BIT_W-1:0] PINB6 = 3'd6;
  localparam logic [BIT_W-1:0] PINC6 = 3'd6;
  localparam logic [BIT_W-1:0] PIND0 = 3'd0;

  typedef struct packed {
    logic              ok;
    logic [PORT_W-1:0] port;
    logic [BIT_W-1:0]  bit_pos;
  } pin_map_t;

  // one job for the result emitter: a status result, or a set of pin events
  typedef struct packed {
    logic                                kind;
    logic [PORT_W-1:0]                   port;
    logic [PINS_PER_PORT-1:0]            mask;
    logic [PINS_PER_PORT-1:0]            levels;
    logic [PINS_PER_PORT-1:0][TAG_W-1:0] tags;
    logic [1:0]                          status;
    logic [EN_W-1:0]                     enables;
  } emit_job_t;

  // package pin to port and bit; power and unused pins are not mapped
  function automatic pin_map_t pin_lookup(input logic [4:0] pin);
    pin_map_t m;
    m = '0;
    case (pin) inside
      5'd1: begin
        m = '{ok: 1'b1, port: PORT_C, bit_pos: PINC6};
      end
      [5'd2:5'd6]: begin
        m = '{ok: 1'b1, port: PORT_D, bit_pos: PIND0 + 3'(pin - 5'd2)};
      end
      [5'd9:5'd10]: begin
        m = '{ok: 1'b1, port: PORT_B, bit_pos: PINB6 + 3'(pin - 5'd9)};
      end
      [5'd11:5'd13]: begin
        m = '{ok: 1'b1, port: PORT_D, bit_pos: 3'(pin - 5'd6)};
      end
      [5'd14:5'd19]: begin
        m = '{ok: 1'b1, port: PORT_B, bit_pos: 3'(pin - 5'd14)};
      end
      [5'd23:5'd28]: begin
        m = '{ok: 1'b1, port: PORT_C, bit_pos: 3'(pin - 5'd23)};
      end
      default: begin
        m = '0;
      end
    endcase
    return m;
  endfunction

endpackage

>>> hw/rtl/pced_emitter.sv
// Result emitter: holds one job and hands out its results, events in bit order
module pced_emitter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  pced_pkg::emit_job_t          job,
  output logic                         free,
  output logic                         valid,
  input  logic                         stall,
  output logic                         kind,
  output logic [pced_pkg::PORT_W-1:0]  event_port,
  output logic [pced_pkg::BIT_W-1:0]   event_bit,
  output logic [pced_pkg::TAG_W-1:0]   event_tag,
  output logic                         event_rising,
  output logic [1:0]                   status,
  output logic [pced_pkg::EN_W-1:0]    port_irq_enables,
  output logic                         last
);
  import pced_pkg::*;

  logic                     busy;
  emit_job_t                jb;
  logic [BIT_W-1:0]         low_idx;
  logic [PINS_PER_PORT-1:0] low_hot;
  logic [PINS_PER_PORT-1:0] rest;

  // lowest pending event bit
  always_comb begin
    low_idx = '0;
    for (int b = PINS_PER_PORT - 1; b >= 0; b--) begin
      if (jb.mask[b]) begin
        low_idx = BIT_W'(b);
      end
    end
    low_hot = PINS_PER_PORT'(1) << low_idx;
    rest = jb.mask & ~low_hot;
  end

  assign last = (jb.kind == KIND_STATUS) || (rest == '0);
  assign valid = busy;
  assign free = !busy || (!stall && last);

  assign kind = jb.kind;
  assign event_port = (jb.kind == KIND_EVENT) ? jb.port : '0;
  assign event_bit = (jb.kind == KIND_EVENT) ? low_idx : '0;
  assign event_tag = (jb.kind == KIND_EVENT) ? jb.tags[low_idx] : '0;
  assign event_rising = (jb.kind == KIND_EVENT) ? jb.levels[low_idx] : 1'b0;
  assign status = (jb.kind == KIND_STATUS) ? jb.status : ST_DONE;
  assign port_irq_enables = jb.enables;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (busy && !stall && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      jb <= job;
    end else if (busy && !stall && !last) begin
      jb.mask <= rest;
    end
  end

endmodule

>>> hw/rtl/pin_change_edge_dispatcher_unit.sv
// Top level of the pin change edge dispatcher
// Usage:
//   Item channel (item_valid / item_stall) takes one transaction per item:
//   a port sample, a handler register or a handler deregister. Result channel
//   (result_valid / result_stall) carries pin events and status results;
//   last marks the final result of an item. Samples with no matching edge
//   and unused mode codes give no result.
// Timing:
//   An accepted item is held in the input register, where the table lookup,
//   edge match and state update happen; its first result is offered once
//   the item has moved from the input register into the result emitter.
//   One item enters per cycle as long as each gives at most one result and
//   result_stall is low; a sample that fires more than one pin holds the
//   result emitter until its last event is taken, and the next item waits.
// Reset (rst, synchronous): all registrations, user counts and stored pin
//   levels clear; no result is pending.
// Stall: while result_stall is high the offered result holds, and while the
//   input register is full and the emitter cannot take its item, item_stall is high; nothing is dropped.
`include "pin_change_edge_dispatcher_unit_macros.svh"

module pin_change_edge_dispatcher_unit #(
  parameter int NUM_PORTS = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [1:0]                   mode,
  input  logic [4:0]                   physical_pin,
  input  logic [pced_pkg::TAG_W-1:0]   handler_tag,
  input  logic                         edge_wanted,
  input  logic [pced_pkg::PORT_W-1:0]  port_select,
  input  logic [7:0]                   pin_levels,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         kind,
  output logic [pced_pkg::PORT_W-1:0]  event_port,
  output logic [pced_pkg::BIT_W-1:0]   event_bit,
  output logic [pced_pkg::TAG_W-1:0]   event_tag,
  output logic                         event_rising,
  output logic [1:0]                   status,
  output logic [pced_pkg::EN_W-1:0]    port_irq_enables,
  output logic                         last
);
  import pced_pkg::*;

  // input register
  logic                     s1_valid;
  logic [1:0]               s1_mode;
  logic [4:0]               s1_pin;
  logic [TAG_W-1:0]         s1_tag;
  logic                     s1_edge;
  logic [PORT_W-1:0]        s1_psel;
  logic [PINS_PER_PORT-1:0] s1_levels;

  // block state
  logic [PINS_PER_PORT-1:0] entry_valid [NUM_PORTS];
  logic [PINS_PER_PORT-1:0] entry_edge [NUM_PORTS];
  logic [TAG_W-1:0]         entry_tag [NUM_PORTS][PINS_PER_PORT];
  logic [3:0]               port_user_count [NUM_PORTS];
  logic [3:0]               port_user_count_next [NUM_PORTS];
  logic [PINS_PER_PORT-1:0] last_levels [NUM_PORTS];

  logic                     emit_free;
  logic                     s1_fire;
  logic                     emit_load;
  emit_job_t                job;

  pin_map_t                 map;
  logic                     pin_ok;
  logic                     port_ok;
  logic                     cur_valid;
  logic [1:0]               reg_status;
  logic                     do_reg;
  logic                     do_dereg;
  logic [PINS_PER_PORT-1:0] row_valid;
  logic [PINS_PER_PORT-1:0] row_edge;
  logic [PINS_PER_PORT-1:0] row_prev;
  logic [PINS_PER_PORT-1:0][TAG_W-1:0] row_tags;
  logic [PINS_PER_PORT-1:0] match;
  logic [EN_W-1:0]          en_now;
  logic [EN_W-1:0]          en_next;

  assign item_stall = s1_valid && !emit_free;
  assign s1_fire = s1_valid && emit_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_mode <= mode;
      s1_pin <= physical_pin;
      s1_tag <= handler_tag;
      s1_edge <= edge_wanted;
      s1_psel <= port_select;
      s1_levels <= pin_levels;
    end
  end

  // lookup and edge match
  always_comb begin
    map = pin_lookup(s1_pin);
    pin_ok = map.ok && (int'(map.port) < NUM_PORTS);
    port_ok = int'(s1_psel) < NUM_PORTS;
    cur_valid = 1'b0;
    row_valid = '0;
    row_edge = '0;
    row_prev = '0;
    row_tags = '0;
    for (int p = 0; p < NUM_PORTS; p++) begin
      if (PORT_W'(p) == map.port) begin
        cur_valid = entry_valid[p][map.bit_pos];
      end
      if (PORT_W'(p) == s1_psel) begin
        row_valid = entry_valid[p];
        row_edge = entry_edge[p];
        row_prev = last_levels[p];
        for (int b = 0; b < PINS_PER_PORT; b++) begin
          row_tags[b] = entry_tag[p][b];
        end
      end
    end
    // changed, registered, and the new level equals the wanted edge
    match = (row_prev ^ s1_levels) & row_valid & ~(row_edge ^ s1_levels);

    do_reg = (s1_mode == MODE_REGISTER) && pin_ok && !cur_valid;
    do_dereg = (s1_mode == MODE_DEREGISTER) && pin_ok && cur_valid;
    if (!pin_ok) begin
      reg_status = ST_INVALID;
    end else if (do_reg || do_dereg) begin
      reg_status = ST_DONE;
    end else begin
      reg_status = ST_UNCHANGED;
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PORTS; p++) begin
      port_user_count_next[p] = port_user_count[p];
      if (s1_fire && PORT_W'(p) == map.port) begin
        if (do_reg) begin
          port_user_count_next[p] = port_user_count[p] + 4'd1;
        end else if (do_dereg) begin
          port_user_count_next[p] = port_user_count[p] - 4'd1;
        end
      end
    end
    en_now = '0;
    en_next = '0;
    for (int p = 0; p < NUM_PORTS; p++) begin
      if (p < EN_W) begin
        en_now[p] = port_user_count[p] != 4'd0;
        en_next[p] = port_user_count_next[p] != 4'd0;
      end
    end
  end

  always_comb begin
    job = '0;
    emit_load = 1'b0;
    if (s1_mode == MODE_SAMPLE) begin
      job.kind = KIND_EVENT;
      job.port = s1_psel;
      job.mask = match;
      job.levels = s1_levels;
      job.tags = row_tags;
      emit_load = s1_fire && port_ok && (match != '0);
    end else begin
      job.kind = KIND_STATUS;
      job.status = reg_status;
      emit_load = s1_fire && (s1_mode == MODE_REGISTER || s1_mode == MODE_DEREGISTER);
    end
    job.enables = en_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        entry_valid[p] <= '0;
        entry_edge[p] <= '0;
        port_user_count[p] <= '0;
        last_levels[p] <= '0;
      end
    end else begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        port_user_count[p] <= port_user_count_next[p];
        if (s1_fire && PORT_W'(p) == map.port) begin
          if (do_reg) begin
            entry_valid[p][map.bit_pos] <= 1'b1;
            entry_edge[p][map.bit_pos] <= s1_edge;
          end else if (do_dereg) begin
            entry_valid[p][map.bit_pos] <= 1'b0;
          end
        end
        if (s1_fire && s1_mode == MODE_SAMPLE && PORT_W'(p) == s1_psel) begin
          last_levels[p] <= s1_levels;
        end
      end
    end
  end

  // tags are only read behind a set valid bit
  always_ff @(posedge clk) begin
    for (int p = 0; p < NUM_PORTS; p++) begin
      if (s1_fire && do_reg && PORT_W'(p) == map.port) begin
        entry_tag[p][map.bit_pos] <= s1_tag;
      end
    end
  end

  pced_emitter u_emit (
    .clk              (clk),
    .rst              (rst),
    .load             (emit_load),
    .job              (job),
    .free             (emit_free),
    .valid            (result_valid),
    .stall            (result_stall),
    .kind             (kind),
    .event_port       (event_port),
    .event_bit        (event_bit),
    .event_tag        (event_tag),
    .event_rising     (event_rising),
    .status           (status),
    .port_irq_enables (port_irq_enables),
    .last             (last)
  );

  `PCED_ASSERT_NEXT(a_reg_enables, s1_fire && s1_mode == MODE_REGISTER && reg_status == ST_DONE, en_now != '0, "registered pin left its port disabled")
  `PCED_ASSERT_NEXT(a_more_events, result_valid && !result_stall && !last, result_valid, "event burst ended without last")
  `PCED_ASSERT_NOW(a_status_last, result_valid && kind == KIND_STATUS, last, "status result not marked last")

endmodule
